@@ src/q2e_pkg.sv @@
package q2e_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TABLE_LEN        = 24;

    // sum and vector widths
    localparam int SUM_W  = 34;
    localparam int VEC_W  = 36;
    localparam int ANG_W  = 26;
    localparam int TAB_W  = 21;

    localparam logic signed [ANG_W-1:0] HALF_TURN = ANG_W'(180 * 32768);
    localparam logic signed [15:0]      DECL_RESET = 16'sd1715;

    localparam logic signed [18:0] LIM_FULL = 19'sd23040;
    localparam logic signed [18:0] LIM_HALF = 19'sd11520;

    // round(atan(2^-i) * 2^15), degrees
    function automatic logic [TAB_W-1:0] atan_step(input int i);
        logic [TAB_W-1:0] v;
        begin
            case (i)
                0:  v = TAB_W'(1474560);
                1:  v = TAB_W'(870484);
                2:  v = TAB_W'(459940);
                3:  v = TAB_W'(233473);
                4:  v = TAB_W'(117189);
                5:  v = TAB_W'(58652);
                6:  v = TAB_W'(29333);
                7:  v = TAB_W'(14667);
                8:  v = TAB_W'(7334);
                9:  v = TAB_W'(3667);
                10: v = TAB_W'(1833);
                11: v = TAB_W'(917);
                12: v = TAB_W'(458);
                13: v = TAB_W'(229);
                14: v = TAB_W'(115);
                15: v = TAB_W'(57);
                16: v = TAB_W'(29);
                17: v = TAB_W'(14);
                18: v = TAB_W'(7);
                19: v = TAB_W'(4);
                20: v = TAB_W'(2);
                21: v = TAB_W'(1);
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

@@ src/q2e_isqrt.sv @@
module q2e_isqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [60:0] val,
    output logic [30:0] root
);
    import q2e_pkg::*;

    localparam int N = 31;

    logic [60:0] rem_reg [0:N-1];
    logic [61:0] res_reg [0:N-1];

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_step
            localparam logic [61:0] BIT = 62'(1) << (60 - 2 * k);
            logic [60:0] rem_in;
            logic [61:0] res_in;
            logic [61:0] trial;
            logic [60:0] rem_next;
            logic [61:0] res_next;

            if (k == 0) begin : g_first
                assign rem_in = val;
                assign res_in = '0;
            end else begin : g_rest
                assign rem_in = rem_reg[k-1];
                assign res_in = res_reg[k-1];
            end

            always_comb
            begin
                trial = res_in + BIT;
                if ({1'b0, rem_in} >= trial)
                begin
                    rem_next = rem_in - trial[60:0];
                    res_next = (res_in >> 1) + BIT;
                end
                else
                begin
                    rem_next = rem_in;
                    res_next = res_in >> 1;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rem_next;
                    res_reg[k] <= res_next;
                end
            end
        end
    endgenerate

    assign root = res_reg[N-1][30:0];

endmodule

@@ src/q2e_cordic.sv @@
module q2e_cordic #(
    parameter int STEPS = q2e_pkg::CORDIC_STEPS_DEF
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [q2e_pkg::SUM_W-1:0]  num,
    input  logic signed [q2e_pkg::SUM_W-1:0]  den,
    output logic signed [q2e_pkg::ANG_W-1:0]  angle
);
    import q2e_pkg::*;

    logic signed [VEC_W-1:0] x_reg [0:STEPS];
    logic signed [VEC_W-1:0] y_reg [0:STEPS];
    logic signed [ANG_W-1:0] z_reg [0:STEPS];
    logic                    zero_reg [0:STEPS];

    // left half plane: turn by 180 degrees first
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= (num == '0) && (den == '0);
            if (den < 0)
            begin
                x_reg[0] <= -VEC_W'(den);
                y_reg[0] <= -VEC_W'(num);
                z_reg[0] <= (num >= 0) ? HALF_TURN : -HALF_TURN;
            end
            else
            begin
                x_reg[0] <= VEC_W'(den);
                y_reg[0] <= VEC_W'(num);
                z_reg[0] <= '0;
            end
        end
    end

    genvar i;
    generate
        for (i = 0; i < STEPS; i++) begin : g_iter
            localparam logic signed [ANG_W-1:0] STEP_ANG =
                ANG_W'($signed({1'b0, atan_step(i)}));
            logic signed [VEC_W-1:0] dx;
            logic signed [VEC_W-1:0] dy;

            assign dx = y_reg[i] >>> i;
            assign dy = x_reg[i] >>> i;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    zero_reg[i+1] <= zero_reg[i];
                    if (y_reg[i] >= 0)
                    begin
                        x_reg[i+1] <= x_reg[i] + dx;
                        y_reg[i+1] <= y_reg[i] - dy;
                        z_reg[i+1] <= z_reg[i] + STEP_ANG;
                    end
                    else
                    begin
                        x_reg[i+1] <= x_reg[i] - dx;
                        y_reg[i+1] <= y_reg[i] + dy;
                        z_reg[i+1] <= z_reg[i] - STEP_ANG;
                    end
                end
            end
        end
    endgenerate

    assign angle = zero_reg[STEPS] ? '0 : z_reg[STEPS];

endmodule

@@ src/quaternion_to_euler_angles.sv @@
// Quaternion to yaw / pitch / roll, fully pipelined.
// Input channel: in_valid / in_ready with quat_w..quat_z (signed Q1.15).
// Output channel: out_valid / out_ready with yaw_angle, pitch_angle,
// roll_angle (1/128 degree) and pitch_clamped.
// cfg_we / cfg_wdata writes the yaw declination; write only while idle.
// The pipeline has 3 stages of products, sums and squaring, 31 stages of
// bit-per-stage square root for the pitch cosine, 1 + CORDIC_STEPS stages
// of CORDIC vectoring in three parallel lanes, and one output stage.
// Throughput is one beat per cycle while the output does not stall.
// The whole pipeline advances on one enable; when out_valid is high and
// out_ready low, every stage holds and in_ready drops, so nothing is lost
// or repeated. Bubbles do not collapse.
// Reset clears all valid bits and loads the declination with 1715
// (13.4 degrees); data registers are not reset.
module quaternion_to_euler_angles #(
    parameter int CORDIC_STEPS = q2e_pkg::CORDIC_STEPS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic signed [15:0] cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [16:0] yaw_angle,
    output logic signed [14:0] pitch_angle,
    output logic signed [15:0] roll_angle,
    output logic               pitch_clamped
);
    import q2e_pkg::*;

    localparam int SQ_STAGES = 31;
    localparam int LAT       = CORDIC_STEPS + 36;

    localparam logic signed [SUM_W-1:0] Q30_ONE = SUM_W'(64'sd1073741824);
    localparam logic [60:0]             Q60_ONE = 61'(1) << 60;

    logic        en;
    logic [LAT-1:0] vld_reg;
    logic signed [15:0] decl_reg;

    // stage 1: products
    logic signed [31:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [31:0] xy_reg, wz_reg, wx_reg, yz_reg, xz_reg, wy_reg;

    // stage 2: sums
    logic signed [SUM_W-1:0] yn_reg, yd_reg, rn_reg, rd_reg;
    logic signed [31:0]      s_reg;
    logic                    clamp_reg;
    logic signed [SUM_W-1:0] s_full;
    logic signed [SUM_W-1:0] s_sat;

    // stage 3 onward: square and delay line
    logic [60:0]             v_reg;
    logic [30:0]             s_abs;
    logic [61:0]             s_sq;
    logic signed [SUM_W-1:0] yn_dly [0:SQ_STAGES];
    logic signed [SUM_W-1:0] yd_dly [0:SQ_STAGES];
    logic signed [SUM_W-1:0] rn_dly [0:SQ_STAGES];
    logic signed [SUM_W-1:0] rd_dly [0:SQ_STAGES];
    logic signed [31:0]      s_dly  [0:SQ_STAGES];
    logic                    cl_dly [0:LAT-3];

    logic [30:0]             c_root;
    logic signed [ANG_W-1:0] yaw_a, pitch_a, roll_a;

    logic signed [16:0] yaw_reg;
    logic signed [14:0] pitch_reg;
    logic signed [15:0] roll_reg;

    function automatic logic signed [18:0] to_units(input logic signed [ANG_W:0] a);
        logic signed [ANG_W:0] t;
        logic signed [18:0]    u;
        begin
            t = (a + (ANG_W+1)'(128)) >>> 8;
            u = t[18:0];
            return u;
        end
    endfunction

    function automatic logic signed [18:0] lim(input logic signed [18:0] v,
                                               input logic signed [18:0] m);
        logic signed [18:0] r;
        begin
            if (v > m)
                r = m;
            else if (v < -m)
                r = -m;
            else
                r = v;
            return r;
        end
    endfunction

    assign en       = !vld_reg[LAT-1] || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            decl_reg <= DECL_RESET;
        end
        else
        begin
            if (en)
                vld_reg <= {vld_reg[LAT-2:0], in_valid};
            if (cfg_we)
                decl_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ww_reg <= quat_w * quat_w;
            xx_reg <= quat_x * quat_x;
            yy_reg <= quat_y * quat_y;
            zz_reg <= quat_z * quat_z;
            xy_reg <= quat_x * quat_y;
            wz_reg <= quat_w * quat_z;
            wx_reg <= quat_w * quat_x;
            yz_reg <= quat_y * quat_z;
            xz_reg <= quat_x * quat_z;
            wy_reg <= quat_w * quat_y;
        end
    end

    always_comb
    begin
        s_full = (SUM_W'(xz_reg) - SUM_W'(wy_reg)) <<< 1;
        if (s_full > Q30_ONE)
            s_sat = Q30_ONE;
        else if (s_full < -Q30_ONE)
            s_sat = -Q30_ONE;
        else
            s_sat = s_full;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            yn_reg    <= (SUM_W'(xy_reg) + SUM_W'(wz_reg)) <<< 1;
            yd_reg    <= SUM_W'(ww_reg) + SUM_W'(xx_reg) - SUM_W'(yy_reg) - SUM_W'(zz_reg);
            rn_reg    <= (SUM_W'(wx_reg) + SUM_W'(yz_reg)) <<< 1;
            rd_reg    <= SUM_W'(ww_reg) - SUM_W'(xx_reg) - SUM_W'(yy_reg) + SUM_W'(zz_reg);
            s_reg     <= s_sat[31:0];
            clamp_reg <= (s_full != s_sat);
        end
    end

    assign s_abs = s_reg[31] ? 31'(-s_reg) : s_reg[30:0];
    assign s_sq  = s_abs * s_abs;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg     <= Q60_ONE - s_sq[60:0];
            yn_dly[0] <= yn_reg;
            yd_dly[0] <= yd_reg;
            rn_dly[0] <= rn_reg;
            rd_dly[0] <= rd_reg;
            s_dly[0]  <= s_reg;
            cl_dly[0] <= clamp_reg;
            for (int k = 1; k <= SQ_STAGES; k++)
            begin
                yn_dly[k] <= yn_dly[k-1];
                yd_dly[k] <= yd_dly[k-1];
                rn_dly[k] <= rn_dly[k-1];
                rd_dly[k] <= rd_dly[k-1];
                s_dly[k]  <= s_dly[k-1];
            end
            for (int k = 1; k <= LAT - 3; k++)
                cl_dly[k] <= cl_dly[k-1];
        end
    end

    q2e_isqrt u_isqrt (
        .clk  (clk),
        .en   (en),
        .val  (v_reg),
        .root (c_root)
    );

    // delay taps line up with the square root output
    q2e_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
        .clk   (clk),
        .en    (en),
        .num   (yn_dly[SQ_STAGES]),
        .den   (yd_dly[SQ_STAGES]),
        .angle (yaw_a)
    );

    q2e_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
        .clk   (clk),
        .en    (en),
        .num   (SUM_W'(s_dly[SQ_STAGES])),
        .den   (SUM_W'({1'b0, c_root})),
        .angle (pitch_a)
    );

    q2e_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
        .clk   (clk),
        .en    (en),
        .num   (rn_dly[SQ_STAGES]),
        .den   (rd_dly[SQ_STAGES]),
        .angle (roll_a)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            yaw_reg   <= 17'(lim(to_units((ANG_W+1)'(yaw_a)), LIM_FULL)) - 17'(decl_reg);
            pitch_reg <= 15'(lim(to_units(-((ANG_W+1)'(pitch_a))), LIM_HALF));
            roll_reg  <= 16'(lim(to_units((ANG_W+1)'(roll_a)), LIM_FULL));
        end
    end

    assign out_valid     = vld_reg[LAT-1];
    assign yaw_angle     = yaw_reg;
    assign pitch_angle   = pitch_reg;
    assign roll_angle    = roll_reg;
    assign pitch_clamped = cl_dly[LAT-3];

endmodule

@@ src/q2e_checker.sv @@
module q2e_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_ready,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [14:0] pitch_angle,
    input  logic signed [15:0] roll_angle
);
    import q2e_pkg::*;

    // a stalled result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // input side freezes exactly when the output stalls
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not follow output stall");

    a_pitch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pitch_angle <= 15'sd11520) && (pitch_angle >= -15'sd11520))
        else $error("pitch out of range");

    a_roll: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (roll_angle <= 16'sd23040) && (roll_angle >= -16'sd23040))
        else $error("roll out of range");

endmodule

bind quaternion_to_euler_angles q2e_checker u_q2e_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pitch_angle (pitch_angle),
    .roll_angle  (roll_angle)
);
